// ===== hdl/pvr_pkg.sv =====
// Shared widths and types for the velocity PID regulator.
`timescale 1ns / 1ps

package pvr_pkg;

    localparam int VEL_W    = 24;  // measured and target velocity
    localparam int GAIN_W   = 24;  // unsigned gains and base throttle
    localparam int LIM_W    = 23;  // clamp limit and integral band
    localparam int PERIOD_W = 16;  // update period in ms
    localparam int TIME_W   = 32;  // millisecond time stamp
    localparam int ERR_W    = 25;  // target - velocity
    localparam int DIFF_W   = 26;  // error - previous error
    localparam int PROD_W   = 50;  // gain times difference, signed
    localparam int DRIVE_W  = 26;  // drive output

    // register index, byte address is 4*index
    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_TARGET     = 3'd3,
        REG_BASE       = 3'd4,
        REG_LIMIT      = 3'd5,
        REG_BAND       = 3'd6,
        REG_PERIOD     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/pvr_mult.sv =====
// Shared registered multiplier: unsigned gain times signed operand.
`timescale 1ns / 1ps

module pvr_mult
    import pvr_pkg::*;
(
    input  logic                     aclk,
    input  logic [GAIN_W-1:0]        gain,
    input  logic signed [DIFF_W-1:0] operand,
    output logic signed [PROD_W-1:0] product
);

    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] product_reg;

    assign gain_s  = $signed({1'b0, gain});
    assign product = product_reg;

    // |gain * operand| < 2^49, so PROD_W bits hold it exactly
    always_ff @(posedge aclk) begin
        product_reg <= PROD_W'(gain_s) * PROD_W'(operand);
    end

endmodule

// ===== hdl/pvr_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module pvr_div
    import pvr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [PROD_W-1:0] dividend,
    input  logic [PERIOD_W-1:0]      divisor,
    output div_stat_t                stat,
    output logic signed [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W);

    logic                     busy_reg;
    logic                     fix_reg;
    logic                     done_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [PROD_W-1:0]        mag_reg;
    logic [PERIOD_W-1:0]      rem_reg;
    logic [PERIOD_W-1:0]      den_reg;
    logic signed [PROD_W-1:0] quot_reg;

    logic [PERIOD_W:0]        rem_sh;
    logic                     ge;
    logic [PERIOD_W:0]        rem_sub;

    assign rem_sh  = {rem_reg, mag_reg[PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    assign stat.busy = busy_reg | fix_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(PROD_W - 1)) begin
                busy_reg <= 1'b0;
                fix_reg  <= 1'b1;
            end else if (fix_reg) begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[PROD_W-1];
            mag_reg <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            mag_reg <= {mag_reg[PROD_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (fix_reg) begin
            quot_reg <= neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

endmodule

// ===== hdl/pid_velocity_regulator.sv =====
// Velocity PID regulator: sequencer, state, register file and output stage.
`timescale 1ns / 1ps

// Velocity PID regulator, Q8.16 fixed point. Each input beat carries a velocity
// sample and its millisecond time; each produces exactly one output beat. A
// sample that arrives within update_period ms of the last update repeats the
// held drive. A sample that triggers an update makes three passes through one
// shared multiplier for the P, I and D products, then waits in the
// one-bit-per-cycle restoring divider that scales the D term by the period,
// then goes through sum, clamp and output. s_ready is high only while the
// sequencer is idle; the output register lets the next sample be taken while
// a result waits. Registers sit at byte address 4*index on the APB port; the
// user must write them only while the block is idle, as the block itself does
// not enforce this.
module pid_velocity_regulator
    import pvr_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int INTEG_WIDTH = 40
)
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VEL_W-1:0]   s_measured_velocity,
    input  logic [TIME_W-1:0]         s_now_ms,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive_value,
    output logic                      m_was_updated
);

    localparam int SUM_W = ((INTEG_WIDTH > PROD_W) ? INTEG_WIDTH : PROD_W) + 2;

    localparam logic signed [SUM_W-1:0] IMAX =
        {{(SUM_W - INTEG_WIDTH + 1){1'b0}}, {(INTEG_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] IMIN = ~IMAX;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ERR    = 4'd1;
    localparam logic [3:0] S_CHK    = 4'd2;
    localparam logic [3:0] S_MP     = 4'd3;
    localparam logic [3:0] S_MI     = 4'd4;
    localparam logic [3:0] S_MD     = 4'd5;
    localparam logic [3:0] S_DSTART = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_SUM    = 4'd8;
    localparam logic [3:0] S_CLAMP  = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    // configuration
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   integ_gain_reg;
    logic [GAIN_W-1:0]   deriv_gain_reg;
    logic [VEL_W-1:0]    target_reg;
    logic [GAIN_W-1:0]   base_reg;
    logic [LIM_W-1:0]    limit_reg;
    logic [LIM_W-1:0]    band_reg;
    logic [PERIOD_W-1:0] period_reg;

    // sequencer and datapath
    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;
    logic signed [VEL_W-1:0]        vel_reg;
    logic [TIME_W-1:0]              now_reg;
    logic signed [ERR_W-1:0]        err_reg;
    logic                           upd_reg;
    logic                           in_band_reg;
    logic signed [PROD_W-1:0]       p_reg;
    logic signed [PROD_W-1:0]       d_reg;
    logic signed [SUM_W-1:0]        sum_reg;

    logic signed [INTEG_WIDTH-1:0]  integ_sum_reg;
    logic signed [ERR_W-1:0]        last_err_reg;
    logic [TIME_W-1:0]              last_upd_reg;
    logic signed [DRIVE_W-1:0]      held_drive_reg;

    logic                           m_valid_reg;
    logic signed [DRIVE_W-1:0]      m_drive_reg;
    logic                           m_upd_reg;

    logic                           cfg_wr;
    logic [TIME_W-1:0]              elapsed;
    logic [ERR_W-1:0]               abs_err;
    logic signed [DIFF_W-1:0]       err_diff;
    logic [GAIN_W-1:0]              mul_gain;
    logic signed [DIFF_W-1:0]       mul_operand;
    logic signed [PROD_W-1:0]       product;
    logic signed [SUM_W-1:0]        integ_raw;
    logic signed [SUM_W-1:0]        integ_sat;
    logic signed [SUM_W-1:0]        lim_pos;
    logic signed [SUM_W-1:0]        pid_clamped;
    logic [PERIOD_W-1:0]            divisor;
    logic                           div_start;
    div_stat_t                      div_stat;
    logic signed [PROD_W-1:0]       quotient;
    logic signed [DRIVE_W:0]        drive_hi;
    logic signed [DRIVE_W:0]        drive_lo;

    // ---------------- APB register file ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= 24'd39322;
            integ_gain_reg <= 24'd33;
            deriv_gain_reg <= 24'd327680;
            target_reg     <= 24'hFE0000;
            base_reg       <= 24'd10813440;
            limit_reg      <= 23'd655360;
            band_reg       <= 23'd39322;
            period_reg     <= 16'd40;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: integ_gain_reg <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: deriv_gain_reg <= pwdata[GAIN_W-1:0];
                REG_TARGET:     target_reg     <= pwdata[VEL_W-1:0];
                REG_BASE:       base_reg       <= pwdata[GAIN_W-1:0];
                REG_LIMIT:      limit_reg      <= pwdata[LIM_W-1:0];
                REG_BAND:       band_reg       <= pwdata[LIM_W-1:0];
                REG_PERIOD:     period_reg     <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_PROP_GAIN:  prdata = 32'(prop_gain_reg);
            REG_INTEG_GAIN: prdata = 32'(integ_gain_reg);
            REG_DERIV_GAIN: prdata = 32'(deriv_gain_reg);
            REG_TARGET:     prdata = 32'(target_reg);
            REG_BASE:       prdata = 32'(base_reg);
            REG_LIMIT:      prdata = 32'(limit_reg);
            REG_BAND:       prdata = 32'(band_reg);
            REG_PERIOD:     prdata = 32'(period_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- shared units ----------------
    assign err_diff = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);

    always_comb begin
        unique case (state_reg)
            S_MI:    begin mul_gain = integ_gain_reg; mul_operand = DIFF_W'(err_reg); end
            S_MD:    begin mul_gain = deriv_gain_reg; mul_operand = err_diff;         end
            default: begin mul_gain = prop_gain_reg;  mul_operand = DIFF_W'(err_reg); end
        endcase
    end

    pvr_mult u_mult (
        .aclk    (aclk),
        .gain    (mul_gain),
        .operand (mul_operand),
        .product (product)
    );

    // a zero period divides by one
    assign divisor   = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign div_start = state_reg == S_DSTART;

    pvr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // ---------------- datapath logic ----------------
    assign elapsed = now_reg - last_upd_reg;
    assign abs_err = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);

    // integral term lands in the product register while in S_MD
    assign integ_raw = SUM_W'(integ_sum_reg) + SUM_W'(product >>> FRAC_BITS);
    always_comb begin
        if (integ_raw > IMAX) begin
            integ_sat = IMAX;
        end else if (integ_raw < IMIN) begin
            integ_sat = IMIN;
        end else begin
            integ_sat = integ_raw;
        end
    end

    // exact sum clamped to +-limit gives the same answer as saturating first
    assign lim_pos = SUM_W'($signed({1'b0, limit_reg}));
    always_comb begin
        if (sum_reg > lim_pos) begin
            pid_clamped = lim_pos;
        end else if (sum_reg < -lim_pos) begin
            pid_clamped = -lim_pos;
        end else begin
            pid_clamped = sum_reg;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_ERR;
            S_ERR:    state_next = S_CHK;
            S_CHK:    state_next = upd_reg ? S_MP : S_OUT;
            S_MP:     state_next = S_MI;
            S_MI:     state_next = S_MD;
            S_MD:     state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:    if (div_stat.done) state_next = S_SUM;
            S_SUM:    state_next = S_CLAMP;
            S_CLAMP:  state_next = S_OUT;
            S_OUT:    if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_sum_reg  <= '0;
            last_err_reg   <= '0;
            last_upd_reg   <= '0;
            held_drive_reg <= '0;
        end else begin
            unique case (state_reg)
                S_CHK: begin
                    if (upd_reg) begin
                        last_upd_reg <= now_reg;
                    end else begin
                        last_err_reg <= err_reg;
                    end
                end
                S_MD: begin
                    if (in_band_reg) begin
                        integ_sum_reg <= INTEG_WIDTH'(integ_sat);
                    end
                end
                S_CLAMP: begin
                    held_drive_reg <= $signed({2'b00, base_reg}) + DRIVE_W'(pid_clamped);
                    last_err_reg   <= err_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            vel_reg <= s_measured_velocity;
            now_reg <= s_now_ms;
        end
        if (state_reg == S_ERR) begin
            err_reg <= ERR_W'($signed(target_reg)) - ERR_W'(vel_reg);
            upd_reg <= elapsed > TIME_W'(period_reg);
        end
        if (state_reg == S_CHK) begin
            in_band_reg <= abs_err < ERR_W'(band_reg);
        end
        if (state_reg == S_MI) begin
            p_reg <= product >>> FRAC_BITS;
        end
        if (state_reg == S_DIV && div_stat.done) begin
            d_reg <= quotient >>> FRAC_BITS;
        end
        if (state_reg == S_SUM) begin
            sum_reg <= SUM_W'(integ_sum_reg) + SUM_W'(p_reg) + SUM_W'(d_reg);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_drive_reg <= held_drive_reg;
            m_upd_reg   <= upd_reg;
        end
    end

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_drive_value = m_drive_reg;
    assign m_was_updated = m_upd_reg;

    // ---------------- assertions ----------------
    assign drive_hi = $signed({3'b000, base_reg}) + $signed({4'b0000, limit_reg});
    assign drive_lo = $signed({3'b000, base_reg}) - $signed({4'b0000, limit_reg});

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat accepted while a sample is in work");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the wait state");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLAMP) |=> ((DRIVE_W + 1)'(held_drive_reg) <= drive_hi &&
                                    (DRIVE_W + 1)'(held_drive_reg) >= drive_lo))
        else $error("new drive outside base +- limit");

endmodule

// ===== dv/pid_velocity_regulator_tb.sv =====
// Self-checking testbench for the velocity PID regulator: directed table, random samples.
`timescale 1ns / 1ps

module pid_velocity_regulator_tb
    import pvr_pkg::*;
();

    localparam int     FRAC        = 16;
    localparam int     QUIET_LIMIT = 3000;
    localparam int     DIR_ROWS_N  = 17;
    localparam int     HOLD_CYCLES = 400;
    localparam longint INTEG_MAX   = 64'sh0000_007F_FFFF_FFFF;
    localparam longint INTEG_MIN   = -INTEG_MAX - 1;
    localparam longint VEL_MAX     = 64'sd8388607;
    localparam longint VEL_MIN     = -64'sd8388608;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      updated;
    } drive_beat_t;

    typedef struct packed {
        logic signed [VEL_W-1:0]   vel;
        logic [TIME_W-1:0]         stamp;
        logic                      typed;
        logic signed [DRIVE_W-1:0] drive;
        logic                      updated;
    } dir_row_t;

    logic                      aclk;
    logic                      aresetn             = 1'b0;
    logic                      psel                = 1'b0;
    logic                      penable             = 1'b0;
    logic                      pwrite              = 1'b0;
    logic [4:0]                paddr               = '0;
    logic [31:0]               pwdata              = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_valid             = 1'b0;
    logic                      s_ready;
    logic signed [VEL_W-1:0]   s_measured_velocity = '0;
    logic [TIME_W-1:0]         s_now_ms            = '0;
    logic                      m_valid;
    logic                      m_ready             = 1'b0;
    logic signed [DRIVE_W-1:0] m_drive_value;
    logic                      m_was_updated;

    // shadow of the register file, reset values
    logic [GAIN_W-1:0]       cfg_kp     = 24'd39322;
    logic [GAIN_W-1:0]       cfg_ki     = 24'd33;
    logic [GAIN_W-1:0]       cfg_kd     = 24'd327680;
    logic signed [VEL_W-1:0] cfg_target = -24'sd131072;
    logic [GAIN_W-1:0]       cfg_base   = 24'd10813440;
    logic [LIM_W-1:0]        cfg_limit  = 23'd655360;
    logic [LIM_W-1:0]        cfg_band   = 23'd39322;
    logic [PERIOD_W-1:0]     cfg_period = 16'd40;

    // regulator state
    longint            integ_acc   = 0;
    longint            prev_err    = 0;
    logic [TIME_W-1:0] last_upd_ms = '0;
    longint            drive_hold  = 0;

    drive_beat_t       drive_queue[$];
    int                mismatch_count = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_left      = 0;
    logic [TIME_W-1:0] clock_ms       = '0;

    // typed drive values: reset, exact-zero error with one D step, both rails
    dir_row_t dir_rows [DIR_ROWS_N] = '{
        '{ 24'sd0,        32'd0,          1'b1, 26'sd0,        1'b0 },
        '{ 24'sd0,        32'd40,         1'b1, 26'sd0,        1'b0 },
        '{ -24'sd131072,  32'd41,         1'b1, 26'sd10829824, 1'b1 },
        '{ 24'sd8388607,  32'd50,         1'b1, 26'sd10829824, 1'b0 },
        '{ -24'sd8388608, 32'd82,         1'b1, 26'sd11468800, 1'b1 },
        '{ 24'sd8388607,  32'd124,        1'b1, 26'sd10158080, 1'b1 },
        '{ -24'sd110000,  32'd170,        1'b0, 26'sd0,        1'b0 },
        '{ -24'sd170394,  32'd211,        1'b0, 26'sd0,        1'b0 },
        '{ -24'sd170393,  32'd260,        1'b0, 26'sd0,        1'b0 },
        '{ -24'sd91751,   32'd301,        1'b0, 26'sd0,        1'b0 },
        '{ -24'sd91750,   32'd342,        1'b0, 26'sd0,        1'b0 },
        '{ -24'sd131072,  32'd382,        1'b0, 26'sd0,        1'b0 },
        '{ 24'sd0,        32'hFFFF_FFF0,  1'b0, 26'sd0,        1'b0 },
        '{ 24'sd0,        32'h0000_0010,  1'b0, 26'sd0,        1'b0 },
        '{ 24'sd65536,    32'h0000_0019,  1'b0, 26'sd0,        1'b0 },
        '{ 24'sd1,        32'h8000_0000,  1'b0, 26'sd0,        1'b0 },
        '{ -24'sd1,       32'h7FFF_FFFF,  1'b0, 26'sd0,        1'b0 }
    };

    pid_velocity_regulator u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_measured_velocity (s_measured_velocity),
        .s_now_ms            (s_now_ms),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_drive_value       (m_drive_value),
        .m_was_updated       (m_was_updated)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic drive_beat_t predict_drive(input logic signed [VEL_W-1:0] vel,
                                                  input logic [TIME_W-1:0] stamp);
        longint            err, mag, p_term, i_step, d_term, pid_sum, divisor, lim;
        logic [TIME_W-1:0] elapsed;
        drive_beat_t       beat;
        err          = longint'(cfg_target) - longint'(vel);
        elapsed      = stamp - last_upd_ms;
        beat.updated = (elapsed > TIME_W'(cfg_period));
        if (beat.updated) begin
            mag    = (err < 0) ? -err : err;
            lim    = longint'(cfg_limit);
            p_term = (longint'(cfg_kp) * err) >>> FRAC;
            // strict band: an error equal to the band leaves the integral alone
            if (mag < longint'(cfg_band)) begin
                i_step    = (longint'(cfg_ki) * err) >>> FRAC;
                integ_acc = integ_acc + i_step;
                if (integ_acc > INTEG_MAX)
                    integ_acc = INTEG_MAX;
                if (integ_acc < INTEG_MIN)
                    integ_acc = INTEG_MIN;
            end
            // zero period divides as one; divide truncates, then floor shift
            divisor = (cfg_period == 0) ? 64'sd1 : longint'(cfg_period);
            d_term  = ((longint'(cfg_kd) * (err - prev_err)) / divisor) >>> FRAC;
            pid_sum = integ_acc + p_term + d_term;
            if (pid_sum < -lim)
                pid_sum = -lim;
            if (pid_sum > lim)
                pid_sum = lim;
            drive_hold  = longint'(cfg_base) + pid_sum;
            last_upd_ms = stamp;
        end
        prev_err   = err;
        beat.drive = drive_hold[DRIVE_W-1:0];
        return beat;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN:  cfg_kp     = value[GAIN_W-1:0];
            REG_INTEG_GAIN: cfg_ki     = value[GAIN_W-1:0];
            REG_DERIV_GAIN: cfg_kd     = value[GAIN_W-1:0];
            REG_TARGET:     cfg_target = value[VEL_W-1:0];
            REG_BASE:       cfg_base   = value[GAIN_W-1:0];
            REG_LIMIT:      cfg_limit  = value[LIM_W-1:0];
            REG_BAND:       cfg_band   = value[LIM_W-1:0];
            REG_PERIOD:     cfg_period = value[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_all(input logic [31:0] kp, ki, kd, target, base, limit, band,
                               input logic [31:0] period);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_TARGET, target);
        write_reg(REG_BASE, base);
        write_reg(REG_LIMIT, limit);
        write_reg(REG_BAND, band);
        write_reg(REG_PERIOD, period);
    endtask

    task automatic send_sample(input logic signed [VEL_W-1:0] vel,
                               input logic [TIME_W-1:0] stamp,
                               input logic typed, input drive_beat_t typed_beat);
        drive_beat_t beat;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_measured_velocity <= vel;
        s_now_ms            <= stamp;
        do @(posedge aclk); while (!s_ready);
        beat = predict_drive(vel, stamp);
        drive_queue.push_back(typed ? typed_beat : beat);
    endtask

    // rail: errors just inside the band and every sample an update, to drive
    // the integral into saturation
    task automatic run_random(input int count, input bit rail);
        longint                  err, v;
        logic signed [VEL_W-1:0] vel;
        int unsigned             pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (rail && cfg_band > 64) begin
                err = longint'(cfg_band) - 1 - longint'($urandom_range(0, cfg_band >> 5));
                v   = longint'(cfg_target) - err;
            end else if (pick < 60) begin
                err = longint'($urandom_range(0, 4 * cfg_band + 4))
                      - 2 * longint'(cfg_band) - 2;
                v   = longint'(cfg_target) - err;
            end else if (pick < 85) begin
                v = longint'($urandom_range(0, 32'h20_0000)) - 64'sd1048576;
            end else begin
                v = longint'($urandom_range(0, 32'hFF_FFFF)) + VEL_MIN;
            end
            if (v > VEL_MAX)
                v = VEL_MAX;
            if (v < VEL_MIN)
                v = VEL_MIN;
            vel  = v[VEL_W-1:0];
            pick = $urandom_range(99);
            if (rail)
                clock_ms = clock_ms + cfg_period + 1 + $urandom_range(0, 3);
            else if (pick < 8)
                clock_ms = $urandom;
            else if (pick < 14)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * cfg_period);
            else
                clock_ms = clock_ms + $urandom_range(0, 2 * cfg_period + 2);
            send_sample(vel, clock_ms, 1'b0, '0);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        drive_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $error("unexpected result beat: drive_value %0d", m_drive_value);
            end else begin
                want = drive_queue.pop_front();
                if (m_drive_value !== want.drive) begin
                    mismatch_count++;
                    if (mismatch_count <= 40)
                        $error("drive_value: expected %0d, got %0d", want.drive,
                               m_drive_value);
                end
                if (m_was_updated !== want.updated) begin
                    mismatch_count++;
                    if (mismatch_count <= 40)
                        $error("was_updated: expected %0b, got %0b", want.updated,
                               m_was_updated);
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** pid_velocity_regulator: FAILED **");
        $finish;
    end

    initial begin
        dir_row_t row;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, no idling
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_sample(row.vel, row.stamp, row.typed, {row.drive, row.updated});
        end
        clock_ms = dir_rows[DIR_ROWS_N-1].stamp;
        run_random(40, 1'b0);

        // mid-range gains, sender idling
        drain();
        send_idle_pct = 63;
        program_all(32'h0002_0000, 32'h0000_0800, 32'h0000_8000, 32'hFFFD_0000,
                    32'h0060_0000, 32'h0010_0000, 32'h0004_0000, 32'd25);
        run_random(60, 1'b0);

        // every register at its top, upper bus bits set; receiver stalling
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h007F_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(50, 1'b0);

        // bottom values, zero period; both sides idling
        drain();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        program_all(32'h0, 32'h0, 32'h0, 32'hFF80_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        run_random(25, 1'b0);
        drain();
        program_all(32'h0001_0000, 32'h0000_0100, 32'h0003_0000, 32'h0000_0000,
                    32'h0001_0000, 32'h007F_FFFF, 32'h007F_FFFF, 32'hABCD_0000);
        run_random(25, 1'b0);

        // random settings; long receiver hold-off fills the block
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    ($urandom & 32'hFFFF_0000) | $urandom_range(1, 100));
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        run_random(40, 1'b0);

        // integral driven into saturation, then back to mixed errors
        drain();
        program_all(32'h0000_0100, 32'h00FF_FFFF, 32'h0000_0100, 32'h007F_FFFF,
                    32'h0040_0000, 32'h007F_FFFF, 32'h007F_FFFF, 32'd1);
        run_random(300, 1'b1);
        run_random(20, 1'b0);

        drain();
        repeat (70) @(posedge aclk);
        if (mismatch_count == 0 && drive_queue.size() == 0)
            $display("** pid_velocity_regulator: PASSED **");
        else
            $display("** pid_velocity_regulator: FAILED **");
        $finish;
    end

endmodule
